// File: sv/dpld_pkg.sv
// package: constants and angle table for the pair line distance pipeline
package dpld_pkg;

  localparam int ROT_W = 34;
  localparam int VEC_W = 52;
  localparam int FIN_W = 50;
  localparam int ANG_W = 34;
  localparam int TAB_LEN = 24;

  localparam logic [15:0] ANGLE_MAX_IN = 16'd51471;
  localparam logic [32:0] PI_Q30 = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage

// File: sv/depth_pair_line_distance.sv
// top level: line distance of a depth pair through three cordic passes
//  channel | dir | contents
//  in_     | in  | beam_angle, depth_a, depth_b
//  out_    | out | line_distance
// one word per cycle when the output is not stalled;
// the whole pipeline advances together when the output register is free or taken
// rst_n clears every valid bit; data registers are not reset
// a stall on out_tready holds every stage and drops in_tready
module depth_pair_line_distance #(
  parameter int DEPTH_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // beam_angle, depth_a, depth_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // line_distance
);

  localparam int RW = dpld_pkg::ROT_W;
  localparam int VW = dpld_pkg::VEC_W;
  localparam int FW = dpld_pkg::FIN_W;
  localparam int AW = dpld_pkg::ANG_W;
  localparam logic [15:0] DMASK =
    (DEPTH_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DEPTH_BITS) - 32'd1);

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // prep stage
  logic [15:0] ang, ang_c, da, db;
  logic [32:0] a_full;
  logic        va_r, neg_r, zero_r;
  logic [15:0] d1_r, d2_r;
  logic signed [AW-1:0] a_r;

  assign ang   = in_tdata[15:0];
  assign da    = in_tdata[31:16] & DMASK;
  assign db    = in_tdata[47:32] & DMASK;
  assign ang_c = (ang > dpld_pkg::ANGLE_MAX_IN) ? dpld_pkg::ANGLE_MAX_IN : ang;
  assign a_full = {1'b0, ang_c, 16'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= (da > db) ? da : db;
      d2_r   <= (da > db) ? db : da;
      zero_r <= (da == 16'd0) && (db == 16'd0);
      if (a_full > dpld_pkg::HALF_PI_Q30) begin
        a_r   <= $signed(AW'(dpld_pkg::PI_Q30 - a_full));
        neg_r <= 1'b1;
      end else begin
        a_r   <= $signed(AW'(a_full));
        neg_r <= 1'b0;
      end
    end
  end

  // pass one: sin and cos
  logic              v1;
  logic signed [RW-1:0] cs1, sn1;
  logic [33:0]       s1;

  dpld_cordic #(.XW(RW), .ZW(AW), .STAGES(CORDIC_STAGES), .SW(34), .VECTORING(1'b0))
    u_sincos (
      .clk(clk), .rst_n(rst_n), .en(en), .valid_i(va_r),
      .x_i($signed({{(RW-30){1'b0}}, dpld_pkg::GAIN_Q30})),
      .y_i('0), .z_i(a_r),
      .side_i({zero_r, neg_r, d1_r, d2_r}),
      .valid_o(v1), .x_o(cs1), .y_o(sn1), .z_o(), .side_o(s1)
    );

  // product stage
  logic signed [RW-1:0] cs_adj;
  logic signed [RW+16:0] pcs_r, psn_r;
  logic [45:0]          pg_r;
  logic [15:0]          d1m_r;
  logic                 vm_r, zm_r;

  assign cs_adj = s1[32] ? -cs1 : cs1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcs_r <= $signed({1'b0, s1[15:0]}) * cs_adj;
      psn_r <= $signed({1'b0, s1[15:0]}) * sn1;
      pg_r  <= s1[31:16] * dpld_pkg::GAIN_Q30;
      d1m_r <= s1[31:16];
      zm_r  <= s1[33];
    end
  end

  // vector setup stage
  logic signed [VW-1:0] xv, xv_r, yv_r;
  logic signed [VW-1:0] yv;
  logic [46:0]          sv_r;
  logic                 vs_r;

  assign xv = $signed({{(VW-46){1'b0}}, d1m_r, 30'b0}) - VW'(pcs_r);
  assign yv = VW'(psn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (en) begin
      vs_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xv_r <= xv[VW-1] ? '0 : xv;
      yv_r <= yv[VW-1] ? '0 : yv;
      sv_r <= {zm_r, pg_r};
    end
  end

  // pass two: beta
  logic              v2;
  logic signed [AW-1:0] beta;
  logic [46:0]       s2;

  dpld_cordic #(.XW(VW), .ZW(AW), .STAGES(CORDIC_STAGES), .SW(47), .VECTORING(1'b1))
    u_beta (
      .clk(clk), .rst_n(rst_n), .en(en), .valid_i(vs_r),
      .x_i(xv_r), .y_i(yv_r), .z_i('0), .side_i(sv_r),
      .valid_o(v2), .x_o(), .y_o(), .z_o(beta), .side_o(s2)
    );

  // pass three: d1 * sin(beta)
  logic              v3, s3;
  logic signed [FW-1:0] y3;

  dpld_cordic #(.XW(FW), .ZW(AW), .STAGES(CORDIC_STAGES), .SW(1), .VECTORING(1'b0))
    u_dist (
      .clk(clk), .rst_n(rst_n), .en(en), .valid_i(v2),
      .x_i($signed({{(FW-46){1'b0}}, s2[45:0]})), .y_i('0), .z_i(beta),
      .side_i(s2[46]),
      .valid_o(v3), .x_o(), .y_o(y3), .z_o(), .side_o(s3)
    );

  // output stage
  logic signed [FW-31:0] res;
  logic                  out_valid_r;
  logic [15:0]           out_data_r;

  assign res = y3[FW-1:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3 || res[FW-31]) begin
        out_data_r <= '0;
      end else if (res > $signed({{(FW-46){1'b0}}, DMASK})) begin
        out_data_r <= DMASK;
      end else begin
        out_data_r <= res[15:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata <= DMASK))
    else $error("line distance above depth range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !va_r && !vm_r && !vs_r)
    else $error("pipeline valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vm_r) && $stable(vs_r) && $stable(xv_r))
    else $error("pipeline moved during stall");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && v3 && s3 |=> out_tdata == 16'd0)
    else $error("zero depth pair gave nonzero distance");
`endif

endmodule

// File: sv/dpld_cordic.sv
// pipelined cordic, one register stage per iteration, rotation or vectoring
module dpld_cordic #(
  parameter int XW = 34,
  parameter int ZW = 34,
  parameter int STAGES = 16,
  parameter int SW = 1,
  parameter bit VECTORING = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic [SW-1:0]        side_o
);

  logic signed [XW-1:0] x_r [0:STAGES-1];
  logic signed [XW-1:0] y_r [0:STAGES-1];
  logic signed [ZW-1:0] z_r [0:STAGES-1];
  logic [SW-1:0]        s_r [0:STAGES-1];
  logic [STAGES-1:0]    v_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] xi, yi, xsh, ysh;
    logic signed [ZW-1:0] zi, at;
    logic [SW-1:0]        si;
    logic                 vi, pos;

    if (i == 0) begin : g_first
      assign xi = x_i;
      assign yi = y_i;
      assign zi = z_i;
      assign si = side_i;
      assign vi = valid_i;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign si = s_r[i-1];
      assign vi = v_r[i-1];
    end

    assign xsh = xi >>> i;
    assign ysh = yi >>> i;
    assign at  = $signed({{(ZW-32){1'b0}}, dpld_pkg::ATAN_TAB[i]});
    assign pos = VECTORING ? yi[XW-1] : !zi[ZW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i] <= si;
        if (pos) begin
          x_r[i] <= xi - ysh;
          y_r[i] <= yi + xsh;
          z_r[i] <= zi - at;
        end else begin
          x_r[i] <= xi + ysh;
          y_r[i] <= yi - xsh;
          z_r[i] <= zi + at;
        end
      end
    end
  end

  assign valid_o = v_r[STAGES-1];
  assign x_o     = x_r[STAGES-1];
  assign y_o     = y_r[STAGES-1];
  assign z_o     = z_r[STAGES-1];
  assign side_o  = s_r[STAGES-1];

endmodule

// File: tb/depth_pair_line_distance_checker.sv
// checker: predicts the line distance of each accepted word and compares results
`timescale 1ns / 100ps

module depth_pair_line_distance_checker #(
  parameter int DEPTH_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  logic [15:0] dist_mem [0:255];
  int wr_cnt;
  int rd_cnt;
  int n_checked;

  function automatic longint atan_q30(int i);
    return longint'(dpld_pkg::ATAN_TAB[i]);
  endfunction

  function automatic void cordic_rotate(inout longint x, inout longint y, input longint z);
    longint xs;
    longint ys;
    for (int i = 0; i < CORDIC_STAGES && i < dpld_pkg::TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_q30(i);
      end else begin
        x += ys; y -= xs; z += atan_q30(i);
      end
    end
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES && i < dpld_pkg::TAB_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_q30(i);
      end else begin
        x -= ys; y += xs; z -= atan_q30(i);
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] line_distance(logic [47:0] word);
    longint lim;
    longint ang;
    longint da;
    longint db;
    longint d1;
    longint d2;
    longint a;
    longint cs;
    longint sn;
    longint x;
    longint y;
    longint beta;
    longint res;
    bit neg_cos;
    lim = (DEPTH_BITS >= 16) ? 64'hFFFF : ((64'd1 << (DEPTH_BITS & 15)) - 1);
    ang = longint'(word[15:0]);
    da = longint'(word[31:16]) & lim;
    db = longint'(word[47:32]) & lim;
    d1 = (da > db) ? da : db;
    d2 = (da > db) ? db : da;
    if (d1 == 0) return '0;
    if (ang > longint'(dpld_pkg::ANGLE_MAX_IN)) ang = longint'(dpld_pkg::ANGLE_MAX_IN);
    a = ang << 16;
    neg_cos = 0;
    if (a > longint'(dpld_pkg::HALF_PI_Q30)) begin
      a = longint'(dpld_pkg::PI_Q30) - a;
      neg_cos = 1;
    end
    cs = longint'(dpld_pkg::GAIN_Q30);
    sn = 0;
    cordic_rotate(cs, sn, a);
    if (neg_cos) cs = -cs;
    x = d1 * (64'sd1 <<< 30) - d2 * cs;
    y = d2 * sn;
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    beta = cordic_angle(x, y);
    x = d1 * longint'(dpld_pkg::GAIN_Q30);
    y = 0;
    cordic_rotate(x, y, beta);
    res = y >>> 30;
    if (res < 0) res = 0;
    if (res > lim) res = lim;
    return res[15:0];
  endfunction

  assign pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      fail_count <= 0;
      n_checked <= 0;
      wr_cnt <= 0;
      rd_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        dist_mem[wr_cnt[7:0]] <= line_distance(in_tdata);
        wr_cnt <= wr_cnt + 1;
      end
      if (out_tvalid && out_tready) begin
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = dist_mem[rd_cnt[7:0]];
          if (out_tdata !== want) begin
            $display("%0t: line_distance mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata);
            fail_count <= fail_count + 1;
          end
          rd_cnt <= rd_cnt + 1;
          n_checked <= n_checked + 1;
        end
      end
    end
  end
endmodule

// File: tb/depth_pair_line_distance_tb.sv
// testbench top: drives depth pairs with random idling and gives the verdict
`timescale 1ns / 100ps

module depth_pair_line_distance_tb;

  localparam int LATENCY = 3 * 16 + 4;
  localparam int N_RANDOM = 1700;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  int          fail_count;
  int          pending;
  bit          no_idle;
  int          n_sent;

  depth_pair_line_distance u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  depth_pair_line_distance_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  task automatic send_word(logic [15:0] ang, logic [15:0] da, logic [15:0] db);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {db, da, ang};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [15:0] ang;
    logic [15:0] da;
    logic [15:0] db;
    case ($urandom_range(5))
      0: ang = 16'($urandom);
      1: ang = 16'($urandom_range(51471, 65535));
      default: ang = 16'($urandom_range(0, 51471));
    endcase
    da = 16'($urandom);
    case ($urandom_range(4))
      0: db = da;
      1: db = 16'(32'(da) + $urandom_range(0, 255) - 32'd128);
      2: db = 16'($urandom_range(0, 3));
      default: db = 16'($urandom);
    endcase
    send_word(ang, da, db);
  endtask

  initial begin
    logic [15:0] angs [0:6];
    angs = '{16'd0, 16'd1, 16'd25735, 16'd25736, 16'd51471, 16'd51472, 16'hFFFF};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    no_idle = 0;
    n_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_word(16'd12000, 16'd0, 16'd0);
    send_word(16'hFFFF, 16'd0, 16'd0);
    for (int i = 0; i < 7; i++) send_word(angs[i], 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 7; i++) send_word(angs[i], 16'hFFFF, 16'd0);
    for (int i = 0; i < 5; i++) send_word(angs[i], 16'd1, 16'd2);
    send_word(16'd100, 16'hAAAA, 16'h5555);
    send_word(16'd30000, 16'h5555, 16'hAAAA);
    drain();
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 600 && i < 900);
      if (i == 1200) drain();
      send_random();
    end
    no_idle = 0;
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d words: zero and full depths, angle limits and clamp, random pairs",
             n_sent);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: sim.f
sv/dpld_pkg.sv
sv/dpld_cordic.sv
sv/depth_pair_line_distance.sv
tb/depth_pair_line_distance_checker.sv
tb/depth_pair_line_distance_tb.sv
